/* sv/rfp_pkg.sv */
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants for the request frame parser with CRC-16 check.
// ----------------------------------------------------------------------------
package rfp_pkg;

    localparam int POS_W      = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] MIN_LENGTH      = 16'd6;
    localparam logic [15:0] QUERY_PAYLOAD   = 16'd4;
    localparam logic [15:0] LED_MIN_PAYLOAD = 16'd5;
    localparam logic [15:0] LEN_OVERHEAD    = 16'd2;

    // Status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_FMT = 2'd1;
    localparam logic [1:0] STATUS_CRC = 2'd2;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HEADER = 2'd0,
        CFG_TAIL   = 2'd1,
        CFG_QUERY  = 2'd2,
        CFG_LED    = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_rfp_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  node_id;
        logic [7:0]  msg_type;
        logic [7:0]  func_code;
        logic [15:0] length_field;
        logic [15:0] first_reg;
        logic [15:0] word_count;
        logic [7:0]  led_level;
        logic        led_valid;
    } t_rfp_out;

endpackage

/* sv/rfp_crc16_byte.sv */
// ----------------------------------------------------------------------------
// rfp_crc16_byte
// One byte of CRC-16/MODBUS (reflected), eight bit steps unrolled.
// ----------------------------------------------------------------------------
module rfp_crc16_byte
    import rfp_pkg::*;
(
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {8'd0, i_byte};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        o_crc = c;
    end

endmodule

/* sv/request_frame_parser_crc16.sv */
// ----------------------------------------------------------------------------
// request_frame_parser_crc16
// Byte-wide request frame parser: header/tail word check, field capture and
// CRC-16/MODBUS verification, one result per received buffer.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle. Each byte updates the frame state in the
// cycle it is accepted; the transaction carrying the last-byte flag loads the
// result register, so the result appears in the cycle after that byte. The only
// pacing element is the result register: input ready drops solely while a
// result is held and the output side has not taken it. Configuration writes
// take effect at once and must only be made between buffers.
module request_frame_parser_crc16
    import rfp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_rfp_in               i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_rfp_out              o_out_data,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Configuration
    logic [31:0] r_header, r_tail;
    logic [7:0]  r_query, r_led_code;

    // Per-buffer state
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_crc, n_crc;
    logic [31:0]      r_shift, n_shift;
    logic [15:0]      r_frame_crc, n_frame_crc;
    logic [7:0]       r_node_id, n_node_id;
    logic [7:0]       r_msg_type, n_msg_type;
    logic [7:0]       r_func, n_func;
    logic [15:0]      r_len, n_len;
    logic [15:0]      r_start, n_start;
    logic [15:0]      r_count, n_count;
    logic [7:0]       r_led, n_led;
    logic             r_hdr_err, n_hdr_err;
    logic             r_tail_err, n_tail_err;

    // Result register
    logic     r_out_valid;
    t_rfp_out r_out_data, n_out_data;

    logic             w_accept;
    logic [7:0]       w_b;
    logic [POS_W-1:0] w_pay;
    logic [POS_W-1:0] w_fin_pay;
    logic [15:0]      w_crc_next;
    logic             w_crc_en;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign w_b         = i_in_data.data_byte;

    // Payload size as placed by the length captured so far (wraps below 2)
    assign w_pay    = {1'b0, r_len - LEN_OVERHEAD};
    assign w_crc_en = (r_pos >= POS_W'(4)) &&
                      ((r_pos <= POS_W'(8)) || (r_pos <= w_pay + POS_W'(8)));

    rfp_crc16_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (w_b),
        .o_crc  (w_crc_next)
    );

    always_comb begin
        n_shift     = r_shift;
        n_hdr_err   = r_hdr_err;
        n_tail_err  = r_tail_err;
        n_frame_crc = r_frame_crc;
        n_node_id   = r_node_id;
        n_msg_type  = r_msg_type;
        n_func      = r_func;
        n_len       = r_len;
        n_start     = r_start;
        n_count     = r_count;
        n_led       = r_led;
        n_crc       = w_crc_en ? w_crc_next : r_crc;
        n_pos       = (r_pos == POS_MAX) ? r_pos : r_pos + 1'b1;

        if (r_pos < POS_W'(4)) begin
            n_shift = {r_shift[23:0], w_b};
            if (r_pos == POS_W'(3) && n_shift != r_header) begin
                n_hdr_err = 1'b1;
            end
        end

        if (r_pos < POS_W'(14)) begin
            case (r_pos[3:0])
                4'd4:    n_node_id      = w_b;
                4'd5:    n_msg_type     = w_b;
                4'd6:    n_func         = w_b;
                4'd7:    n_len[15:8]    = w_b;
                4'd8:    n_len[7:0]     = w_b;
                4'd9:    n_start[15:8]  = w_b;
                4'd10:   n_start[7:0]   = w_b;
                4'd11:   n_count[15:8]  = w_b;
                4'd12:   n_count[7:0]   = w_b;
                4'd13:   n_led          = w_b;
                default: ;
            endcase
        end

        if (r_pos > POS_W'(8)) begin
            if (r_pos == w_pay + POS_W'(9) || r_pos == w_pay + POS_W'(10)) begin
                n_frame_crc = {r_frame_crc[7:0], w_b};
            end
            if (r_pos >= w_pay + POS_W'(11) && r_pos <= w_pay + POS_W'(14)) begin
                n_shift = {r_shift[23:0], w_b};
                if (r_pos == w_pay + POS_W'(14) && n_shift != r_tail) begin
                    n_tail_err = 1'b1;
                end
            end
        end
    end

    // Verdict, judged on the state as it stands after this byte
    assign w_fin_pay = {1'b0, n_len - LEN_OVERHEAD};

    always_comb begin
        logic ledv;
        logic [1:0] st;
        ledv = 1'b0;
        // buffer length n = pos + 1: n < 19 or n < 15 + payload
        if (r_pos < POS_W'(18) || n_hdr_err || n_len < MIN_LENGTH ||
            r_pos < w_fin_pay + POS_W'(14)) begin
            st = STATUS_FMT;
        end else if (n_func == r_query) begin
            st = (n_len - LEN_OVERHEAD != QUERY_PAYLOAD) ? STATUS_FMT : STATUS_OK;
        end else if (n_func == r_led_code) begin
            if (n_len - LEN_OVERHEAD < LED_MIN_PAYLOAD) begin
                st = STATUS_FMT;
            end else begin
                st   = STATUS_OK;
                ledv = 1'b1;
            end
        end else begin
            st = STATUS_FMT;
        end
        if (st == STATUS_OK) begin
            if (n_frame_crc != n_crc) begin
                st = STATUS_CRC;
            end else if (n_tail_err) begin
                st = STATUS_FMT;
            end
        end
        n_out_data.status       = st;
        n_out_data.node_id      = n_node_id;
        n_out_data.msg_type     = n_msg_type;
        n_out_data.func_code    = n_func;
        n_out_data.length_field = n_len;
        n_out_data.first_reg    = n_start;
        n_out_data.word_count   = n_count;
        n_out_data.led_level    = ledv ? n_led : 8'd0;
        n_out_data.led_valid    = ledv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= '0;
            r_tail      <= '0;
            r_query     <= '0;
            r_led_code  <= '0;
            r_pos       <= '0;
            r_crc       <= CRC_INIT;
            r_shift     <= '0;
            r_frame_crc <= '0;
            r_node_id   <= '0;
            r_msg_type  <= '0;
            r_func      <= '0;
            r_len       <= '0;
            r_start     <= '0;
            r_count     <= '0;
            r_led       <= '0;
            r_hdr_err   <= 1'b0;
            r_tail_err  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_HEADER: r_header   <= i_cfg_wdata[31:0];
                    CFG_TAIL:   r_tail     <= i_cfg_wdata[31:0];
                    CFG_QUERY:  r_query    <= i_cfg_wdata[7:0];
                    CFG_LED:    r_led_code <= i_cfg_wdata[7:0];
                    default:    ;
                endcase
            end

            if (w_accept && i_in_data.last_byte) begin
                // buffer closed: back to the empty-frame state
                r_pos       <= '0;
                r_crc       <= CRC_INIT;
                r_shift     <= '0;
                r_frame_crc <= '0;
                r_node_id   <= '0;
                r_msg_type  <= '0;
                r_func      <= '0;
                r_len       <= '0;
                r_start     <= '0;
                r_count     <= '0;
                r_led       <= '0;
                r_hdr_err   <= 1'b0;
                r_tail_err  <= 1'b0;
            end else if (w_accept) begin
                r_pos       <= n_pos;
                r_crc       <= n_crc;
                r_shift     <= n_shift;
                r_frame_crc <= n_frame_crc;
                r_node_id   <= n_node_id;
                r_msg_type  <= n_msg_type;
                r_func      <= n_func;
                r_len       <= n_len;
                r_start     <= n_start;
                r_count     <= n_count;
                r_led       <= n_led;
                r_hdr_err   <= n_hdr_err;
                r_tail_err  <= n_tail_err;
            end

            if (w_accept && i_in_data.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_in_data.last_byte) begin
            r_out_data <= n_out_data;
        end
    end

    // A pending result must never be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while result transaction stalled");

    a_result_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.last_byte) |=>
        (r_out_valid && r_pos == '0 && r_crc == CRC_INIT))
        else $error("last byte did not produce a result and clear the frame");

    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !i_in_data.last_byte && r_pos != POS_MAX) |=>
        (r_pos == $past(r_pos) + 1'b1))
        else $error("byte position did not advance");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.status == STATUS_OK ||
                         r_out_data.status == STATUS_FMT ||
                         r_out_data.status == STATUS_CRC))
        else $error("undefined status code");

    a_led_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data.led_valid) |-> (r_out_data.led_level == 8'd0))
        else $error("LED value set without LED request");

endmodule
